FILE: src/pcmx_pkg.sv
// shared constants, types and helpers for the pcm mixer
`timescale 1ns / 1ps
`default_nettype none
package pcmx_pkg;

    localparam int N_STREAMS  = 4;
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int SUM_W      = 10 + $clog2(N_STREAMS);

    localparam logic [7:0] MID_LEVEL = 8'd128;
    localparam logic [7:0] TOP_LEVEL = 8'd255;

    typedef enum logic [1:0] {
        MODE_OPEN  = 2'd0,
        MODE_CLOSE = 2'd1,
        MODE_PUSH  = 2'd2,
        MODE_MIX   = 2'd3
    } t_mode;

    typedef struct packed {
        logic                 valid;
        logic                 mix;
        logic [N_STREAMS-1:0] use_mask;
        logic                 any_data;
        logic                 dropped;
    } t_stage;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

endpackage
`default_nettype wire

FILE: src/pcmx_ram.sv
// simple dual-port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module pcmx_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: src/pcmx_ctrl.sv
// stream pointers, active mask and per-beat command decode
`timescale 1ns / 1ps
`default_nettype none
module pcmx_ctrl (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire logic                                              i_valid,
    input  wire pcmx_pkg::t_mode                                   i_mode,
    input  wire logic [1:0]                                        i_stream,
    input  wire logic                                              i_take,
    output logic                                                   o_ready,
    output logic                                                   o_rd_en,
    output logic [pcmx_pkg::N_STREAMS-1:0]                         o_wr_en,
    output logic [pcmx_pkg::N_STREAMS-1:0][pcmx_pkg::PTR_W-1:0]    o_wr_addr,
    output logic [pcmx_pkg::N_STREAMS-1:0][pcmx_pkg::PTR_W-1:0]    o_rd_addr,
    output pcmx_pkg::t_stage                                       o_stage
);
    import pcmx_pkg::*;

    logic [N_STREAMS-1:0][PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [N_STREAMS-1:0][PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [N_STREAMS-1:0]            r_active, n_active;
    t_stage                          r_stage, n_stage;
    logic [N_STREAMS-1:0]            wr_en;
    logic                            accept;

    assign o_ready = !r_stage.valid || i_take;
    assign accept  = i_valid && o_ready;

    always_comb begin
        logic hit;
        logic empty;
        logic full;
        n_wr_ptr         = r_wr_ptr;
        n_rd_ptr         = r_rd_ptr;
        n_active         = r_active;
        wr_en            = '0;
        n_stage          = '0;
        n_stage.valid    = 1'b1;
        n_stage.mix      = (i_mode == MODE_MIX);
        for (int k = 0; k < N_STREAMS; k++) begin
            hit   = (32'(i_stream) == k);
            empty = (r_wr_ptr[k] == r_rd_ptr[k]);
            full  = (next_ptr(r_wr_ptr[k]) == r_rd_ptr[k]);
            if (r_active[k] && !empty) begin
                n_stage.any_data = 1'b1;
            end
            case (i_mode)
                MODE_MIX: begin
                    if (r_active[k] && !empty) begin
                        n_stage.use_mask[k] = 1'b1;
                        n_rd_ptr[k]         = next_ptr(r_rd_ptr[k]);
                    end
                end
                MODE_OPEN, MODE_CLOSE: begin
                    if (hit) begin
                        n_active[k] = (i_mode == MODE_OPEN);
                        n_wr_ptr[k] = '0;
                        n_rd_ptr[k] = '0;
                    end
                end
                MODE_PUSH: begin
                    if (hit) begin
                        n_active[k] = 1'b1;
                        if (full) begin
                            n_stage.dropped = 1'b1;
                        end else begin
                            wr_en[k]    = 1'b1;
                            n_wr_ptr[k] = next_ptr(r_wr_ptr[k]);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_active <= '0;
            r_stage  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= n_wr_ptr;
                r_rd_ptr <= n_rd_ptr;
                r_active <= n_active;
                r_stage  <= n_stage;
            end else if (i_take) begin
                r_stage.valid <= 1'b0;
            end
        end
    end

    assign o_rd_en   = accept;
    assign o_wr_en   = wr_en & {N_STREAMS{accept}};
    assign o_wr_addr = r_wr_ptr;
    assign o_rd_addr = r_rd_ptr;
    assign o_stage   = r_stage;

`ifndef SYNTH
    for (genvar g = 0; g < N_STREAMS; g++) begin : g_ptr_chk
        assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (32'(r_wr_ptr[g]) < FIFO_DEPTH) && (32'(r_rd_ptr[g]) < FIFO_DEPTH))
            else $error("stream pointer out of range");
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage.valid && r_stage.dropped |-> !r_stage.mix)
        else $error("drop flagged on a mix beat");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage.valid && !r_stage.mix |-> r_stage.use_mask == '0)
        else $error("stream data used on a non-mix beat");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_stage.valid)
        else $error("accepted beat lost before the output stage");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage.valid && !i_take |=> $stable(r_stage) && $stable(r_rd_ptr))
        else $error("stalled stage or read pointers changed");
`endif

endmodule
`default_nettype wire

FILE: src/pcmx_mix.sv
// sums the popped bytes around the midpoint, clamps, and holds the result beat
`timescale 1ns / 1ps
`default_nettype none
module pcmx_mix (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire pcmx_pkg::t_stage                        i_stage,
    input  wire logic [pcmx_pkg::N_STREAMS-1:0][7:0]     i_rd_data,
    input  wire logic                                    i_m_tready,
    output logic                                         o_take,
    output logic                                         o_m_tvalid,
    output logic [7:0]                                   o_sample,
    output logic                                         o_any_data,
    output logic                                         o_dropped
);
    import pcmx_pkg::*;

    logic [SUM_W-1:0] acc;
    logic [7:0]       clamped;
    logic             r_valid;
    logic [7:0]       r_sample;
    logic             r_any_data;
    logic             r_dropped;

    always_comb begin
        acc = SUM_W'(MID_LEVEL);
        for (int k = 0; k < N_STREAMS; k++) begin
            if (i_stage.use_mask[k]) begin
                acc = acc + SUM_W'(i_rd_data[k]) - SUM_W'(MID_LEVEL);
            end
        end
        if (acc[SUM_W-1]) begin
            clamped = '0;
        end else if (|acc[SUM_W-2:8]) begin
            clamped = TOP_LEVEL;
        end else begin
            clamped = acc[7:0];
        end
    end

    assign o_take = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_stage.valid) begin
            r_sample   <= clamped;
            r_any_data <= i_stage.any_data;
            r_dropped  <= i_stage.dropped;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_sample   = r_sample;
    assign o_any_data = r_any_data;
    assign o_dropped  = r_dropped;

endmodule
`default_nettype wire

FILE: src/multi_stream_pcm_mixer_unit.sv
// top level of the multi-stream pcm mixer
//
// Mixes up to four unsigned 8-bit PCM streams, each buffered in its own ring
// FIFO memory bank of 256 entries (255 usable). Each input beat opens, closes
// or pushes a byte into a stream, or requests one mixed sample; every beat
// gives exactly one result beat. One beat is accepted per clock cycle while
// the result path is not stalled. The FIFO banks are read at the accepting
// edge, together with the stage register, and the sum-and-clamp output
// register loads from them once it is free. A stalled result holds the
// input back only once both stages are full. All banks are read in parallel
// at their read pointers, so a four-way mix costs no more than a push. No
// clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module multi_stream_pcm_mixer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic [3:0] i_s_tuser,   // [1:0] mode, [3:2] stream
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] sample
    output logic [1:0]      o_m_tuser    // [0] any_data, [1] dropped
);
    import pcmx_pkg::*;

    logic                            rd_en;
    logic                            take;
    logic [N_STREAMS-1:0]            wr_en;
    logic [N_STREAMS-1:0][PTR_W-1:0] wr_addr;
    logic [N_STREAMS-1:0][PTR_W-1:0] rd_addr;
    logic [N_STREAMS-1:0][7:0]       rd_data;
    t_stage                          stage;

    pcmx_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_mode    (t_mode'(i_s_tuser[1:0])),
        .i_stream  (i_s_tuser[3:2]),
        .i_take    (take),
        .o_ready   (o_s_tready),
        .o_rd_en   (rd_en),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr),
        .o_stage   (stage)
    );

    for (genvar g = 0; g < N_STREAMS; g++) begin : g_bank
        pcmx_ram #(
            .DEPTH (FIFO_DEPTH),
            .WIDTH (8)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en[g]),
            .i_wr_addr (wr_addr[g]),
            .i_wr_data (i_s_tdata),
            .i_rd_en   (rd_en),
            .i_rd_addr (rd_addr[g]),
            .o_rd_data (rd_data[g])
        );
    end

    pcmx_mix u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage    (stage),
        .i_rd_data  (rd_data),
        .i_m_tready (i_m_tready),
        .o_take     (take),
        .o_m_tvalid (o_m_tvalid),
        .o_sample   (o_m_tdata),
        .o_any_data (o_m_tuser[0]),
        .o_dropped  (o_m_tuser[1])
    );

endmodule
`default_nettype wire
